@@ hdl/lnpa_pkg.sv @@
// Shared action and status codes for the linked node pool allocator.
`default_nettype none

package lnpa_pkg;

  localparam int ACT_BITS  = 3;
  localparam int STAT_BITS = 2;

  localparam logic [ACT_BITS-1:0] ACT_ALLOC   = 3'd0;
  localparam logic [ACT_BITS-1:0] ACT_RELEASE = 3'd1;
  localparam logic [ACT_BITS-1:0] ACT_WRITE   = 3'd2;
  localparam logic [ACT_BITS-1:0] ACT_READ    = 3'd3;
  localparam logic [ACT_BITS-1:0] ACT_QUERY   = 3'd4;

  localparam logic [STAT_BITS-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_NOSPACE  = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_NOTFOUND = 2'd2;

endpackage

`default_nettype wire

@@ hdl/lnpa_node_ram.sv @@
// Node memory: one write port, one registered read port, write-first on collision.
`default_nettype none

module lnpa_node_ram #(
  parameter int DEPTH     = 64,
  parameter int ADDR_BITS = 6,
  parameter int DATA_BITS = 48
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [DATA_BITS-1:0] wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] mem_q;
  logic [DATA_BITS-1:0] fwd_data;
  logic                 fwd_hit;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q    <= mem[raddr];
    fwd_hit  <= we && (waddr == raddr);
    fwd_data <= wdata;
  end

  assign rdata = fwd_hit ? fwd_data : mem_q;

endmodule

`default_nettype wire

@@ hdl/lnpa_ctrl.sv @@
// Sequencer: clears the node memory, then runs allocate, release, chain search and query.
`default_nettype none

module lnpa_ctrl #(
  parameter int NODES      = 64,
  parameter int KEY_BITS   = 8,
  parameter int VALUE_BITS = 32,
  localparam int AW    = $clog2(NODES),
  localparam int CW    = $clog2(NODES + 1),
  localparam int ROW_W = KEY_BITS + VALUE_BITS + CW + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [lnpa_pkg::ACT_BITS-1:0] in_action,
  input  wire logic [AW-1:0]                 in_address,
  input  wire logic [KEY_BITS-1:0]           in_key,
  input  wire logic signed [VALUE_BITS-1:0]  in_value,
  input  wire logic [CW-1:0]                 in_count,
  input  wire logic                          in_first,
  input  wire logic                          in_last,
  output logic                               mem_we,
  output logic [AW-1:0]                      mem_waddr,
  output logic [ROW_W-1:0]                   mem_wdata,
  output logic [AW-1:0]                      mem_raddr,
  input  wire logic [ROW_W-1:0]              mem_rdata,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output logic [lnpa_pkg::STAT_BITS-1:0]     res_status,
  output logic [AW-1:0]                      res_head,
  output logic signed [VALUE_BITS-1:0]       res_read_value,
  output logic                               res_is_free,
  output logic [CW-1:0]                      free_total
);

  localparam int LW = CW;
  localparam logic [LW-1:0] NIL     = LW'(NODES);
  localparam logic [CW-1:0] N_COUNT = CW'(NODES);
  localparam logic [AW-1:0] LAST_IX = AW'(NODES - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_AL_CHECK, S_AL_LINK,
    S_FIND, S_REL_FIRST, S_REL_NEXT, S_QUERY, S_EMIT
  } state_t;

  state_t state;

  // latched item
  logic [lnpa_pkg::ACT_BITS-1:0] act_r;
  logic [AW-1:0]                 addr_r;
  logic [KEY_BITS-1:0]           key_r;
  logic signed [VALUE_BITS-1:0]  val_r;
  logic [CW-1:0]                 cnt_r;
  logic                          first_r;
  logic                          last_r;

  // pool state
  logic [LW-1:0] free_head;
  logic [AW-1:0] alloc_head;
  logic [CW-1:0] alloc_cursor;
  logic [LW-1:0] alloc_tail;

  // walk registers
  logic [AW-1:0]    clr_idx;
  logic [AW-1:0]    cur;
  logic [CW-1:0]    steps;
  logic [AW-1:0]    rel_t;
  logic [ROW_W-1:0] rel_row;
  logic [CW-1:0]    rel_cnt;

  // row fields, layout {key, value, link, free}
  logic                  row_free;
  logic [LW-1:0]         row_link;
  logic [VALUE_BITS-1:0] row_value;
  logic [KEY_BITS-1:0]   row_key;

  assign row_free  = mem_rdata[0];
  assign row_link  = mem_rdata[LW:1];
  assign row_value = mem_rdata[LW+VALUE_BITS:LW+1];
  assign row_key   = mem_rdata[ROW_W-1:ROW_W-KEY_BITS];

  logic            addr_bad;
  logic            alloc_go;
  logic            al_ok;
  logic [CW-1:0]   find_steps1;
  logic            find_stop;
  logic [AW-1:0]   step_t;
  logic [CW-1:0]   step_c1;
  logic            step_stop;
  logic            rel_break;
  logic [CW-1:0]   commit_cnt;
  logic [CW:0]     total_sum;
  logic [CW-1:0]   total_next;

  assign addr_bad    = CW'(addr_r) >= N_COUNT;
  assign alloc_go    = first_r ? (cnt_r != '0 && cnt_r <= free_total) : (alloc_cursor != '0);
  assign al_ok       = row_free && (free_total != '0);
  assign find_steps1 = steps + CW'(1);
  assign find_stop   = (row_link >= NIL) || (find_steps1 >= N_COUNT);
  assign step_t      = (state == S_REL_FIRST) ? addr_r : cur;
  assign step_c1     = ((state == S_REL_FIRST) ? '0 : rel_cnt) + CW'(1);
  assign step_stop   = (row_link >= NIL) || (step_c1 >= N_COUNT);
  assign rel_break   = (state == S_REL_NEXT) && row_free;
  assign commit_cnt  = rel_break ? rel_cnt : step_c1;
  assign total_sum   = {1'b0, free_total} + {1'b0, commit_cnt};
  assign total_next  = (total_sum > {1'b0, N_COUNT}) ? N_COUNT : total_sum[CW-1:0];

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = mem_rdata;
    mem_raddr = addr_r;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = {{KEY_BITS{1'b0}}, {VALUE_BITS{1'b0}}, LW'(clr_idx) + LW'(1), 1'b1};
      end
      S_DECODE: begin
        if (act_r == lnpa_pkg::ACT_ALLOC) begin
          mem_raddr = free_head[AW-1:0];
        end
      end
      S_AL_CHECK: begin
        mem_raddr = alloc_tail[AW-1:0];
        if (al_ok) begin
          mem_we    = 1'b1;
          mem_waddr = free_head[AW-1:0];
          mem_wdata = {key_r, row_value, NIL, 1'b0};
        end
      end
      S_AL_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = alloc_tail[AW-1:0];
        mem_wdata = {row_key, row_value, LW'(cur), row_free};
      end
      S_FIND: begin
        mem_raddr = row_link[AW-1:0];
        if (!row_free && row_key == key_r && act_r == lnpa_pkg::ACT_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = cur;
          mem_wdata = {row_key, val_r, row_link, row_free};
        end
      end
      S_REL_FIRST, S_REL_NEXT: begin
        mem_raddr = row_link[AW-1:0];
        if (rel_break) begin
          // chain ended on a free node: close the previous one onto the free list
          mem_we    = 1'b1;
          mem_waddr = rel_t;
          mem_wdata = {rel_row[ROW_W-1:LW+1], free_head, 1'b1};
        end else if (!row_free) begin
          mem_we    = 1'b1;
          mem_waddr = step_t;
          mem_wdata = {mem_rdata[ROW_W-1:LW+1], step_stop ? free_head : row_link, 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      free_head    <= '0;
      free_total   <= N_COUNT;
      alloc_head   <= '0;
      alloc_cursor <= '0;
      alloc_tail   <= NIL;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == LAST_IX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            act_r   <= in_action;
            addr_r  <= in_address;
            key_r   <= in_key;
            val_r   <= in_value;
            cnt_r   <= in_count;
            first_r <= in_first;
            last_r  <= in_last;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_status     <= lnpa_pkg::STAT_OK;
          res_head       <= '0;
          res_read_value <= '0;
          res_is_free    <= 1'b0;
          cur            <= addr_r;
          steps          <= '0;
          unique case (act_r)
            lnpa_pkg::ACT_ALLOC: begin
              if (first_r) begin
                alloc_tail   <= NIL;
                alloc_cursor <= alloc_go ? cnt_r : '0;
                if (alloc_go) begin
                  alloc_head <= free_head[AW-1:0];
                end
              end
              if (!alloc_go) begin
                res_status <= lnpa_pkg::STAT_NOSPACE;
                state      <= S_EMIT;
              end else if (free_head >= NIL) begin
                alloc_cursor <= '0;
                res_status   <= lnpa_pkg::STAT_NOSPACE;
                state        <= S_EMIT;
              end else begin
                state <= S_AL_CHECK;
              end
            end
            lnpa_pkg::ACT_RELEASE: begin
              if (addr_bad) begin
                res_status <= lnpa_pkg::STAT_NOTFOUND;
                state      <= S_EMIT;
              end else begin
                state <= S_REL_FIRST;
              end
            end
            lnpa_pkg::ACT_WRITE, lnpa_pkg::ACT_READ: begin
              if (addr_bad) begin
                res_status <= lnpa_pkg::STAT_NOTFOUND;
                state      <= S_EMIT;
              end else begin
                state <= S_FIND;
              end
            end
            lnpa_pkg::ACT_QUERY: begin
              state <= addr_bad ? S_EMIT : S_QUERY;
            end
            default: begin
              state <= S_EMIT;
            end
          endcase
        end
        S_AL_CHECK: begin
          if (!al_ok) begin
            alloc_cursor <= '0;
            res_status   <= lnpa_pkg::STAT_NOSPACE;
            state        <= S_EMIT;
          end else begin
            free_head    <= row_link;
            free_total   <= free_total - CW'(1);
            alloc_cursor <= last_r ? '0 : alloc_cursor - CW'(1);
            res_head     <= alloc_head;
            cur          <= free_head[AW-1:0];
            if (alloc_tail < NIL) begin
              state <= S_AL_LINK;
            end else begin
              alloc_tail <= free_head;
              state      <= S_EMIT;
            end
          end
        end
        S_AL_LINK: begin
          alloc_tail <= LW'(cur);
          state      <= S_EMIT;
        end
        S_FIND: begin
          if (row_free) begin
            res_status <= lnpa_pkg::STAT_NOTFOUND;
            state      <= S_EMIT;
          end else if (row_key == key_r) begin
            if (act_r == lnpa_pkg::ACT_READ) begin
              res_read_value <= row_value;
            end
            state <= S_EMIT;
          end else if (find_stop) begin
            res_status <= lnpa_pkg::STAT_NOTFOUND;
            state      <= S_EMIT;
          end else begin
            cur   <= row_link[AW-1:0];
            steps <= find_steps1;
          end
        end
        S_REL_FIRST, S_REL_NEXT: begin
          if (state == S_REL_FIRST && row_free) begin
            res_status <= lnpa_pkg::STAT_NOTFOUND;
            state      <= S_EMIT;
          end else if (rel_break || step_stop) begin
            alloc_cursor <= '0;
            free_head    <= LW'(addr_r);
            free_total   <= total_next;
            state        <= S_EMIT;
          end else begin
            alloc_cursor <= '0;
            rel_t        <= step_t;
            rel_row      <= mem_rdata;
            rel_cnt      <= step_c1;
            cur          <= row_link[AW-1:0];
            state        <= S_REL_NEXT;
          end
        end
        S_QUERY: begin
          res_is_free <= row_free;
          state       <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/linked_node_pool_allocator_unit.sv @@
// Top level of the linked node pool allocator: stream ports, node memory, sequencer, result register.
`default_nettype none

// A pool of NODES nodes (key, value, link) kept in one synchronous node memory,
// starting as a single free list. After reset the block sweeps the memory once
// and keeps s_tready low meanwhile. Items are handled one at a time by a
// sequencer that reads a node, decides, and writes it back; the chain walks
// for release, write and read run at one memory read per link. The result
// sits in an output register, so the next transaction can be taken while the
// previous result waits on m_tready.
module linked_node_pool_allocator_unit #(
  parameter int NODES      = 64,
  parameter int KEY_BITS   = 8,
  parameter int VALUE_BITS = 32,
  localparam int AW       = $clog2(NODES),
  localparam int CW       = $clog2(NODES + 1),
  localparam int IN_BITS  = AW + KEY_BITS + VALUE_BITS + CW,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = lnpa_pkg::STAT_BITS + AW + VALUE_BITS + 1 + 2 * CW,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // address, key, value, request_count
  input  wire logic [IN_W-1:0]                 s_tdata,
  // action, first_of_request
  input  wire logic [lnpa_pkg::ACT_BITS:0]     s_tuser,
  // last_of_request
  input  wire logic                            s_tlast,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // status, head_address, read_value, is_free, free_count, used_count
  output logic [OUT_W-1:0]                     m_tdata
);

  localparam int ROW_W = KEY_BITS + VALUE_BITS + CW + 1;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [ROW_W-1:0] mem_rdata;

  logic                               res_valid;
  logic                               slot_free;
  logic [lnpa_pkg::STAT_BITS-1:0]     res_status;
  logic [AW-1:0]                      res_head;
  logic signed [VALUE_BITS-1:0]       res_read_value;
  logic                               res_is_free;
  logic [CW-1:0]                      free_total;
  logic [CW-1:0]                      used_total;

  lnpa_node_ram #(
    .DEPTH     (NODES),
    .ADDR_BITS (AW),
    .DATA_BITS (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lnpa_ctrl #(
    .NODES      (NODES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_action      (s_tuser[lnpa_pkg::ACT_BITS-1:0]),
    .in_address     (s_tdata[AW-1:0]),
    .in_key         (s_tdata[AW +: KEY_BITS]),
    .in_value       (s_tdata[AW+KEY_BITS +: VALUE_BITS]),
    .in_count       (s_tdata[AW+KEY_BITS+VALUE_BITS +: CW]),
    .in_first       (s_tuser[lnpa_pkg::ACT_BITS]),
    .in_last        (s_tlast),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata),
    .res_valid      (res_valid),
    .res_ready      (slot_free),
    .res_status     (res_status),
    .res_head       (res_head),
    .res_read_value (res_read_value),
    .res_is_free    (res_is_free),
    .free_total     (free_total)
  );

  assign slot_free  = !m_tvalid || m_tready;
  assign used_total = CW'(NODES) - free_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && slot_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && slot_free) begin
      m_tdata <= OUT_W'({used_total, free_total, res_is_free, res_read_value,
                         res_head, res_status});
    end
  end

endmodule

`default_nettype wire

@@ hdl/lnpa_checker.sv @@
// Port-level checks for the linked node pool allocator, bound to the top level.
`default_nettype none

module lnpa_checker #(
  parameter int NODES      = 64,
  parameter int KEY_BITS   = 8,
  parameter int VALUE_BITS = 32,
  localparam int AW       = $clog2(NODES),
  localparam int CW       = $clog2(NODES + 1),
  localparam int IN_BITS  = AW + KEY_BITS + VALUE_BITS + CW,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = lnpa_pkg::STAT_BITS + AW + VALUE_BITS + 1 + 2 * CW,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tvalid,
  input wire logic                        s_tready,
  input wire logic [IN_W-1:0]             s_tdata,
  input wire logic [lnpa_pkg::ACT_BITS:0] s_tuser,
  input wire logic                        s_tlast,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [OUT_W-1:0]            m_tdata
);

  localparam int SB = lnpa_pkg::STAT_BITS;

  logic [SB-1:0]         st;
  logic [AW-1:0]         head;
  logic [VALUE_BITS-1:0] rdv;
  logic [CW-1:0]         fc;
  logic [CW-1:0]         uc;

  assign st   = m_tdata[SB-1:0];
  assign head = m_tdata[SB +: AW];
  assign rdv  = m_tdata[SB+AW +: VALUE_BITS];
  assign fc   = m_tdata[SB+AW+VALUE_BITS+1 +: CW];
  assign uc   = m_tdata[SB+AW+VALUE_BITS+1+CW +: CW];

  // one item in flight: an accepted transaction blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in flight");

  a_counts_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, fc} + {1'b0, uc}) == (CW + 1)'(NODES))
    else $error("free and used counts do not add up to the pool size");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable({s_tdata, s_tuser, s_tlast}))
    else $error("waiting input transaction changed");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st != lnpa_pkg::STAT_OK |-> head == '0 && rdv == '0)
    else $error("failed transaction carries head or read data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind linked_node_pool_allocator_unit lnpa_checker #(
  .NODES      (NODES),
  .KEY_BITS   (KEY_BITS),
  .VALUE_BITS (VALUE_BITS)
) u_lnpa_checker (.*);

`default_nettype wire

@@ tb/sv/linked_node_pool_allocator_checker.sv @@
// Checker for the linked node pool allocator: shadow pool, result prediction and compare.
module linked_node_pool_allocator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic [3:0]  s_tuser,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  output int          fail_count,
  output int          checked,
  output int          pending,
  output logic [1:0]  last_status,
  output logic [5:0]  last_head,
  output logic [6:0]  pool_free
);

  localparam int NODES = 64;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  address;
    logic [7:0]  key;
    logic [31:0] value;
    logic [6:0]  count;
    logic        first;
    logic        last;
  } pool_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  head;
    logic [31:0] read_value;
    logic        is_free;
    logic [6:0]  free_count;
    logic [6:0]  used_count;
  } pool_result_t;

  // shadow of the node pool; NODES stands for the null link
  logic [7:0]  key_mem[NODES];
  logic [31:0] val_mem[NODES];
  int          link_mem[NODES];
  bit          free_mem[NODES];
  int          free_head;
  int          free_total;
  int          open_head;
  int          keys_left;
  int          open_tail;

  pool_result_t result_q[$];
  pool_item_t   item;
  pool_result_t want;
  pool_result_t got;

  function automatic void clear_pool();
    for (int i = 0; i < NODES; i++) begin
      key_mem[i]  = '0;
      val_mem[i]  = '0;
      link_mem[i] = i + 1;
      free_mem[i] = 1'b1;
    end
    free_head  = 0;
    free_total = NODES;
    open_head  = 0;
    keys_left  = 0;
    open_tail  = NODES;
  endfunction

  // walk stops at null, at a free node or after NODES links
  function automatic int find_key(int start, logic [7:0] k);
    int p;
    int steps;
    p = start;
    steps = 0;
    while (p < NODES && !free_mem[p] && steps < NODES) begin
      if (key_mem[p] == k) return p;
      p = link_mem[p];
      steps++;
    end
    return NODES;
  endfunction

  function automatic logic [1:0] free_chain(int start);
    int t;
    int cnt;
    int nx;
    if (start >= NODES || free_mem[start]) return lnpa_pkg::STAT_NOTFOUND;
    keys_left = 0;
    t = start;
    cnt = 0;
    forever begin
      free_mem[t] = 1'b1;
      cnt++;
      nx = link_mem[t];
      if (nx >= NODES || free_mem[nx] || cnt >= NODES) break;
      t = nx;
    end
    link_mem[t] = free_head;
    free_head = start;
    free_total += cnt;
    if (free_total > NODES) free_total = NODES;
    return lnpa_pkg::STAT_OK;
  endfunction

  function automatic logic [1:0] take_node(pool_item_t it, output logic [5:0] head);
    int n;
    head = '0;
    if (it.first) begin
      keys_left = 0;
      open_tail = NODES;
      if (it.count == 0 || it.count > free_total) return lnpa_pkg::STAT_NOSPACE;
      keys_left = it.count;
      open_head = free_head;
    end else if (keys_left == 0) begin
      return lnpa_pkg::STAT_NOSPACE;
    end
    n = free_head;
    if (n >= NODES || !free_mem[n] || free_total == 0) begin
      keys_left = 0;
      return lnpa_pkg::STAT_NOSPACE;
    end
    free_head = link_mem[n];
    key_mem[n] = it.key;
    free_mem[n] = 1'b0;
    link_mem[n] = NODES;
    if (open_tail < NODES) link_mem[open_tail] = n;
    open_tail = n;
    free_total--;
    keys_left--;
    if (it.last) keys_left = 0;
    head = open_head[5:0];
    return lnpa_pkg::STAT_OK;
  endfunction

  function automatic pool_result_t predict_result(pool_item_t it);
    pool_result_t r;
    logic [5:0] h;
    int p;
    r = '0;
    case (it.action)
      lnpa_pkg::ACT_ALLOC: begin
        r.status = take_node(it, h);
        r.head = h;
      end
      lnpa_pkg::ACT_RELEASE: r.status = free_chain(it.address);
      lnpa_pkg::ACT_WRITE: begin
        p = find_key(it.address, it.key);
        if (p < NODES) val_mem[p] = it.value;
        else r.status = lnpa_pkg::STAT_NOTFOUND;
      end
      lnpa_pkg::ACT_READ: begin
        p = find_key(it.address, it.key);
        if (p < NODES) r.read_value = val_mem[p];
        else r.status = lnpa_pkg::STAT_NOTFOUND;
      end
      lnpa_pkg::ACT_QUERY: r.is_free = free_mem[it.address];
      default: ;
    endcase
    r.free_count = free_total[6:0];
    r.used_count = 7'(NODES - free_total);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    checked = 0;
    pending = 0;
    last_status = '0;
    last_head = '0;
    pool_free = 7'(NODES);
    clear_pool();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_pool();
      result_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        item.address = s_tdata[5:0];
        item.key     = s_tdata[13:6];
        item.value   = s_tdata[45:14];
        item.count   = s_tdata[52:46];
        item.action  = s_tuser[2:0];
        item.first   = s_tuser[3];
        item.last    = s_tlast;
        want = predict_result(item);
        result_q.push_back(want);
        last_status = want.status;
        last_head = want.head;
      end
      if (m_tvalid && m_tready) begin
        got.status     = m_tdata[1:0];
        got.head       = m_tdata[7:2];
        got.read_value = m_tdata[39:8];
        got.is_free    = m_tdata[40];
        got.free_count = m_tdata[47:41];
        got.used_count = m_tdata[54:48];
        if (result_q.size() == 0) begin
          $error("unexpected result transaction, m_tdata %0h", m_tdata);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          check_field("status", want.status, got.status);
          check_field("head_address", want.head, got.head);
          check_field("read_value", want.read_value, got.read_value);
          check_field("is_free", want.is_free, got.is_free);
          check_field("free_count", want.free_count, got.free_count);
          check_field("used_count", want.used_count, got.used_count);
          checked++;
        end
      end
    end
    pending = result_q.size();
    pool_free = free_total[6:0];
  end

endmodule

@@ tb/sv/linked_node_pool_allocator_unit_test.sv @@
// Testbench top for the linked node pool allocator: stimulus, output stalls, watchdog, verdict.
module linked_node_pool_allocator_unit_test;

  localparam int ITEMS      = 1450;
  localparam int CALM_AFTER = 1250;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 400;
  localparam int WATCHDOG   = 3000;

  typedef struct {
    logic [5:0] head;
    logic [7:0] key;
  } chain_key_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic [3:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;

  int         fail_count;
  int         checked;
  int         pending;
  logic [1:0] last_status;
  logic [5:0] last_head;
  logic [6:0] pool_free;

  bit idle_on;
  bit hold_req;
  int sent;
  int act_count[8];
  int stall_run;

  // chains believed allocated, and the keys put into them
  logic [5:0] chain_heads[$];
  chain_key_t chain_keys[$];

  linked_node_pool_allocator_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  linked_node_pool_allocator_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .checked     (checked),
    .pending     (pending),
    .last_status (last_status),
    .last_head   (last_head),
    .pool_free   (pool_free)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // entered and left at a falling edge
  task automatic send_item(logic [2:0] act, logic [5:0] adr, logic [7:0] k, logic [31:0] v,
                           logic [6:0] cnt, bit fst, bit lst);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, cnt, v, k, adr};
    s_tuser  <= {fst, act};
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent++;
    act_count[act]++;
  endtask

  task automatic send_alloc(logic [6:0] cnt, logic [7:0] k, bit fst, bit lst);
    send_item(lnpa_pkg::ACT_ALLOC, 6'($urandom), k, $urandom, cnt, fst, lst);
    if (last_status == lnpa_pkg::STAT_OK) begin
      if (fst) chain_heads.push_back(last_head);
      chain_keys.push_back('{last_head, k});
    end
  endtask

  task automatic release_head(logic [5:0] h);
    send_item(lnpa_pkg::ACT_RELEASE, h, 8'($urandom), $urandom, 7'($urandom_range(0, 64)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    for (int i = chain_heads.size() - 1; i >= 0; i--)
      if (chain_heads[i] == h) chain_heads.delete(i);
    for (int i = chain_keys.size() - 1; i >= 0; i--)
      if (chain_keys[i].head == h) chain_keys.delete(i);
  endtask

  task automatic send_access(logic [2:0] act, logic [5:0] h, logic [7:0] k, logic [31:0] v);
    send_item(act, h, k, v, 7'($urandom_range(0, 64)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  // write or read, mostly on a key that some chain holds
  task automatic random_access(logic [2:0] act);
    logic [5:0]  h;
    logic [7:0]  k;
    logic [31:0] v;
    int i;
    if (chain_keys.size() > 0 && $urandom_range(0, 6) != 0) begin
      i = $urandom_range(0, chain_keys.size() - 1);
      h = chain_keys[i].head;
      k = chain_keys[i].key;
      if ($urandom_range(0, 9) == 0) k = 8'($urandom);
    end else begin
      h = 6'($urandom);
      k = 8'($urandom);
    end
    case ($urandom_range(0, 9))
      0: v = 32'h0000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'h8000_0000;
      3: v = 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    send_access(act, h, k, v);
  endtask

  // one allocate request: mostly well formed, sometimes refused, cut short or left open
  task automatic random_request();
    int pf;
    int cnt;
    int items;
    int r;
    bit no_last;
    logic [7:0] k;
    pf = pool_free;
    r = $urandom_range(0, 19);
    if (r == 0) cnt = 0;
    else if (r == 1) cnt = 64;
    else if (r == 2) cnt = pf;
    else if (r == 3) cnt = (pf < 64) ? pf + 1 : 64;
    else cnt = $urandom_range(1, (pf < 1) ? 1 : ((pf < 6) ? pf : 6));
    if (cnt == 0 || cnt > pf) items = $urandom_range(1, 3);
    else if ($urandom_range(0, 7) == 0) items = $urandom_range(1, cnt);
    else items = cnt;
    no_last = ($urandom_range(0, 9) == 0);
    k = 8'($urandom);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 4) != 0) k = 8'($urandom);
      send_alloc((i == 0) ? 7'(cnt) : 7'($urandom_range(0, 64)), k, i == 0,
                 (i == items - 1) && !no_last);
    end
  endtask

  // output side: random stall bursts, plus one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin
    stall_run = 0;
    while (stall_run < WATCHDOG) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_run = 0;
      else stall_run++;
    end
    $display("Timeout: no transaction for %0d cycles", WATCHDOG);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [5:0] head_a;
    logic [5:0] head_c;
    int pick;
    int phase;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    s_tlast = 1'b0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    sent = 0;
    phase = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed: fresh pool, walks on free nodes, refused requests
    send_item(lnpa_pkg::ACT_QUERY, 6'd0, 8'h00, 32'h0, 7'd0, 1'b0, 1'b0);
    send_item(lnpa_pkg::ACT_QUERY, 6'd63, 8'hFF, 32'hFFFF_FFFF, 7'd64, 1'b1, 1'b1);
    send_access(lnpa_pkg::ACT_READ, 6'd7, 8'h5A, 32'h0);
    release_head(6'd5);
    send_alloc(7'd3, 8'h12, 1'b0, 1'b0);
    send_alloc(7'd0, 8'h01, 1'b1, 1'b0);
    send_alloc(7'd2, 8'h02, 1'b0, 1'b1);
    // count at its maximum, chain ended early by the last flag
    send_alloc(7'd64, 8'h00, 1'b1, 1'b0);
    head_a = last_head;
    send_alloc(7'd64, 8'hFF, 1'b0, 1'b1);
    send_alloc(7'd1, 8'h13, 1'b0, 1'b0);
    // a new request opens while one is still open
    send_alloc(7'd3, 8'h11, 1'b1, 1'b0);
    send_alloc(7'd2, 8'h22, 1'b1, 1'b0);
    head_c = last_head;
    send_alloc(7'd2, 8'h33, 1'b0, 1'b1);
    send_access(lnpa_pkg::ACT_WRITE, head_a, 8'hFF, 32'h7FFF_FFFF);
    send_access(lnpa_pkg::ACT_WRITE, head_a, 8'h00, 32'h8000_0000);
    send_access(lnpa_pkg::ACT_READ, head_a, 8'hFF, 32'h0);
    send_access(lnpa_pkg::ACT_READ, head_a, 8'h00, 32'h0);
    send_access(lnpa_pkg::ACT_READ, head_a, 8'h77, 32'h0);
    send_access(lnpa_pkg::ACT_WRITE, head_c, 8'h99, 32'h1234_5678);
    send_item(lnpa_pkg::ACT_QUERY, head_c, 8'h00, 32'h0, 7'd0, 1'b0, 1'b0);
    // release closes an open request
    send_alloc(7'd2, 8'h44, 1'b1, 1'b0);
    release_head(head_a);
    send_alloc(7'd2, 8'h55, 1'b0, 1'b0);
    send_item(3'd5, 6'd1, 8'h00, 32'h0, 7'd0, 1'b0, 1'b0);
    send_item(3'd7, 6'd2, 8'hFF, 32'hFFFF_FFFF, 7'd64, 1'b1, 1'b1);
    send_alloc(7'd64, 8'hAB, 1'b1, 1'b1);
    release_head(head_c);
    release_head(head_c);
    send_item(lnpa_pkg::ACT_QUERY, head_c, 8'h00, 32'h0, 7'd0, 1'b0, 1'b0);

    while (sent < ITEMS) begin
      if (sent >= HOLD_AT) hold_req = 1'b1;
      if (sent >= CALM_AFTER) begin
        idle_on = 1'b0;
      end else if (sent / 100 != phase) begin
        phase = sent / 100;
        idle_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pool_free < 10 && $urandom_range(0, 1) == 0) pick = 30;
      if (pick < 30) begin
        random_request();
      end else if (pick < 50) begin
        if (chain_heads.size() > 0 && $urandom_range(0, 6) != 0)
          release_head(chain_heads[$urandom_range(0, chain_heads.size() - 1)]);
        else
          release_head(6'($urandom));
      end else if (pick < 73) begin
        random_access(lnpa_pkg::ACT_WRITE);
      end else if (pick < 95) begin
        random_access(lnpa_pkg::ACT_READ);
      end else if (pick < 98) begin
        send_item(lnpa_pkg::ACT_QUERY, 6'($urandom), 8'($urandom), $urandom,
                  7'($urandom_range(0, 64)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else if (pick < 99) begin
        send_item(3'($urandom_range(5, 7)), 6'($urandom), 8'($urandom), $urandom,
                  7'($urandom_range(0, 64)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        send_alloc(7'($urandom_range(0, 64)), 8'($urandom), 1'b0,
                   1'($urandom_range(0, 1)));
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);

    $display("Run covered %0d transactions in, %0d results checked, one long output hold",
             sent, checked);
    $display("Mix: %0d allocate, %0d release, %0d write, %0d read, %0d query, %0d unused",
             act_count[lnpa_pkg::ACT_ALLOC], act_count[lnpa_pkg::ACT_RELEASE],
             act_count[lnpa_pkg::ACT_WRITE], act_count[lnpa_pkg::ACT_READ],
             act_count[lnpa_pkg::ACT_QUERY],
             act_count[5] + act_count[6] + act_count[7]);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
